FILE: rtl/lmbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner package
// Shared sizes, register and column byte codes, and the scan result record.
// ----------------------------------------------------------------------------
package lmbs_pkg;

    localparam int ROW_COUNT_DEFAULT   = 8;
    localparam int PLANE_COUNT_DEFAULT = 3;
    localparam int BYTES_PER_ROW       = 3;

    localparam int ROW_W   = 3;
    localparam int PLANE_W = 2;
    localparam int COL_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int THIRD_W = 2;
    localparam int CFG_W   = 2;

    localparam logic [BYTE_W-1:0] DWELL_ZERO_RESET    = 8'd5;
    localparam logic [BYTE_W-1:0] DWELL_ONE_RESET     = 8'd8;
    localparam logic [BYTE_W-1:0] DWELL_TWO_RESET     = 8'd20;
    localparam logic [BYTE_W-1:0] CURRENT_DWELL_RESET = 8'd20;
    localparam logic [BYTE_W-1:0] ROW_MASK_FIRST      = 8'h01;

    typedef enum logic [CFG_W-1:0] {
        CFG_DWELL_ZERO = 2'd0,
        CFG_DWELL_ONE  = 2'd1,
        CFG_DWELL_TWO  = 2'd2
    } t_cfg_index;

    typedef enum logic [COL_W-1:0] {
        COL_FIRST  = 2'd0,
        COL_SECOND = 2'd1,
        COL_THIRD  = 2'd2
    } t_col_byte;

    typedef struct packed {
        logic [BYTE_W-1:0] row_select;
        logic [BYTE_W-1:0] dwell;
        logic              press_event;
        logic [BYTE_W-1:0] press_pattern;
    } t_scan_result;

endpackage
`default_nettype wire

FILE: rtl/lmbs_frame_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix frame store
// One registered-read memory holding the column bytes of a plane and row
// (two bits of the third) in one word, written one column byte at a time, with
// per-byte valid bits so that unwritten bytes read as zero.
// ----------------------------------------------------------------------------
module lmbs_frame_store #(
    parameter int DEPTH = lmbs_pkg::PLANE_COUNT_DEFAULT * lmbs_pkg::ROW_COUNT_DEFAULT
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_we,
    input  wire logic [lmbs_pkg::COL_W-1:0]                   i_wcol,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [lmbs_pkg::BYTE_W-1:0]                  i_wdata,
    input  wire logic                                         i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [lmbs_pkg::BYTE_W-1:0]                  o_first,
    output logic      [lmbs_pkg::BYTE_W-1:0]                  o_second,
    output logic      [lmbs_pkg::THIRD_W-1:0]                 o_third
);
    import lmbs_pkg::*;

    localparam int WORD_W = 2 * BYTE_W + THIRD_W;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid_first;
    logic [DEPTH-1:0]  r_valid_second;
    logic [DEPTH-1:0]  r_valid_third;
    logic [WORD_W-1:0] r_rdata;
    logic [WORD_W-1:0] rd_mask;

    assign rd_mask = {{BYTE_W{r_valid_first[i_raddr]}},
                      {BYTE_W{r_valid_second[i_raddr]}},
                      {THIRD_W{r_valid_third[i_raddr]}}};

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            case (i_wcol)
                COL_FIRST:  r_mem[i_waddr][WORD_W-1 -: BYTE_W] <= i_wdata;
                COL_SECOND: r_mem[i_waddr][THIRD_W +: BYTE_W]  <= i_wdata;
                COL_THIRD:  r_mem[i_waddr][THIRD_W-1:0]        <= i_wdata[THIRD_W-1:0];
                default: ;
            endcase
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr] & rd_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_first  <= '0;
            r_valid_second <= '0;
            r_valid_third  <= '0;
        end else if (i_we) begin
            case (i_wcol)
                COL_FIRST:  r_valid_first[i_waddr]  <= 1'b1;
                COL_SECOND: r_valid_second[i_waddr] <= 1'b1;
                COL_THIRD:  r_valid_third[i_waddr]  <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_first  = r_rdata[WORD_W-1 -: BYTE_W];
    assign o_second = r_rdata[THIRD_W +: BYTE_W];
    assign o_third  = r_rdata[THIRD_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/lmbs_scan_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix scan controller
// Row and plane counters, row mask, dwell registers and button pattern logic.
// ----------------------------------------------------------------------------
module lmbs_scan_ctrl #(
    parameter int ROW_COUNT   = lmbs_pkg::ROW_COUNT_DEFAULT,
    parameter int PLANE_COUNT = lmbs_pkg::PLANE_COUNT_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lmbs_pkg::CFG_W-1:0]    i_cfg_index,
    input  wire logic [lmbs_pkg::BYTE_W-1:0]   i_cfg_data,
    input  wire logic                          i_tick,
    input  wire logic                          i_button_level,
    output logic      [lmbs_pkg::ROW_W-1:0]    o_row,
    output logic      [lmbs_pkg::PLANE_W-1:0]  o_plane,
    output lmbs_pkg::t_scan_result             o_result
);
    import lmbs_pkg::*;

    localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(ROW_COUNT - 1);
    localparam logic [PLANE_W-1:0] PLANE_LAST = PLANE_W'(PLANE_COUNT - 1);

    logic [BYTE_W-1:0]  r_dwell_zero;
    logic [BYTE_W-1:0]  r_dwell_one;
    logic [BYTE_W-1:0]  r_dwell_two;
    logic [ROW_W-1:0]   r_row,      n_row;
    logic [PLANE_W-1:0] r_plane,    n_plane;
    logic [BYTE_W-1:0]  r_row_mask, n_row_mask;
    logic [BYTE_W-1:0]  r_dwell,    n_dwell;
    logic [BYTE_W-1:0]  r_shift,    n_shift;
    logic [BYTE_W-1:0]  r_prev,     n_prev;
    logic [BYTE_W-1:0]  shifted;
    logic               last_row;
    logic               press;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_zero <= DWELL_ZERO_RESET;
            r_dwell_one  <= DWELL_ONE_RESET;
            r_dwell_two  <= DWELL_TWO_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DWELL_ZERO: r_dwell_zero <= i_cfg_data;
                CFG_DWELL_ONE:  r_dwell_one  <= i_cfg_data;
                CFG_DWELL_TWO:  r_dwell_two  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        last_row = (r_row == ROW_LAST);
        n_dwell  = r_dwell;
        if (r_row == '0) begin
            n_row_mask = ROW_MASK_FIRST;
            case (r_plane)
                2'd0:    n_dwell = r_dwell_zero;
                2'd1:    n_dwell = r_dwell_one;
                2'd2:    n_dwell = r_dwell_two;
                default: n_dwell = r_dwell;
            endcase
        end else begin
            n_row_mask = {r_row_mask[BYTE_W-2:0], 1'b0};
        end
        shifted = {i_button_level, r_shift[BYTE_W-1:1]};
        if (last_row) begin
            n_row   = '0;
            n_plane = (r_plane == PLANE_LAST) ? '0 : r_plane + 1'b1;
            press   = |(~r_prev & shifted);
            n_prev  = shifted;
            n_shift = '0;
        end else begin
            n_row   = r_row + 1'b1;
            n_plane = r_plane;
            press   = 1'b0;
            n_prev  = r_prev;
            n_shift = shifted;
        end
        o_result.row_select    = n_row_mask;
        o_result.dwell         = n_dwell;
        o_result.press_event   = press;
        o_result.press_pattern = press ? shifted : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_plane    <= '0;
            r_row_mask <= ROW_MASK_FIRST;
            r_dwell    <= CURRENT_DWELL_RESET;
            r_shift    <= '0;
            r_prev     <= '0;
        end else if (i_tick) begin
            r_row      <= n_row;
            r_plane    <= n_plane;
            r_row_mask <= n_row_mask;
            r_dwell    <= n_dwell;
            r_shift    <= n_shift;
            r_prev     <= n_prev;
        end
    end

    assign o_row   = r_row;
    assign o_plane = r_plane;

endmodule
`default_nettype wire

FILE: rtl/led_matrix_bitplane_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner
// Scans a multiplexed LED matrix from a frame store with brightness planes.
//
// The input channel (i_valid / o_stall) carries one request per cycle: a scan
// tick (i_kind = 0) or a frame store byte write (i_kind = 1). A write updates
// the store and produces nothing. A tick produces one result on the output
// channel (o_valid / i_stall): the row select, the row's column bits from the
// current plane, the dwell compare value and the button press report.
// An accepted tick passes the registered read of the frame store, with its
// scan result held beside it, and then the output register; while the
// output does not stall, requests are taken at one per cycle.
// When the receiver stalls, the output register holds and one more tick may
// wait in the read stage; beyond that o_stall is raised. Writes pass the
// same input stall.
// Reset clears the frame store (through per-byte valid bits), the scan and
// button state and loads the default dwell registers. Configuration writes
// go straight to the dwell registers and take effect at the next row zero.
// ----------------------------------------------------------------------------
module led_matrix_bitplane_scanner #(
    parameter int ROW_COUNT   = lmbs_pkg::ROW_COUNT_DEFAULT,
    parameter int PLANE_COUNT = lmbs_pkg::PLANE_COUNT_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lmbs_pkg::CFG_W-1:0]    i_cfg_index,
    input  wire logic [lmbs_pkg::BYTE_W-1:0]   i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_kind,
    input  wire logic [lmbs_pkg::PLANE_W-1:0]  i_write_plane,
    input  wire logic [lmbs_pkg::ROW_W-1:0]    i_write_row,
    input  wire logic [lmbs_pkg::COL_W-1:0]    i_write_column_byte,
    input  wire logic [lmbs_pkg::BYTE_W-1:0]   i_write_data,
    input  wire logic                          i_button_level,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [lmbs_pkg::BYTE_W-1:0]   o_row_select,
    output logic      [lmbs_pkg::BYTE_W-1:0]   o_columns_first,
    output logic      [lmbs_pkg::BYTE_W-1:0]   o_columns_second,
    output logic      [lmbs_pkg::THIRD_W-1:0]  o_columns_third,
    output logic      [lmbs_pkg::BYTE_W-1:0]   o_dwell_compare,
    output logic                               o_press_event,
    output logic      [lmbs_pkg::BYTE_W-1:0]   o_press_pattern
);
    import lmbs_pkg::*;

    localparam int DEPTH = PLANE_COUNT * ROW_COUNT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic               in_accept;
    logic               tick_accept;
    logic               write_ok;
    logic               out_free;
    logic               s1_advance;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [ROW_W-1:0]   scan_row;
    logic [PLANE_W-1:0] scan_plane;
    t_scan_result       scan_result;
    logic [BYTE_W-1:0]  rd_first;
    logic [BYTE_W-1:0]  rd_second;
    logic [THIRD_W-1:0] rd_third;

    logic               r_s1_valid;
    t_scan_result       r_s1;
    logic               r_out_valid;
    t_scan_result       r_out;
    logic [BYTE_W-1:0]  r_out_first;
    logic [BYTE_W-1:0]  r_out_second;
    logic [THIRD_W-1:0] r_out_third;

    assign out_free    = !r_out_valid || !i_stall;
    assign s1_advance  = r_s1_valid && out_free;
    assign o_stall     = r_s1_valid && !out_free;
    assign in_accept   = i_valid && !o_stall;
    assign tick_accept = in_accept && !i_kind;

    assign write_ok = in_accept && i_kind
                   && (32'(i_write_plane) < PLANE_COUNT)
                   && (32'(i_write_row) < ROW_COUNT)
                   && (32'(i_write_column_byte) < BYTES_PER_ROW);
    assign wr_addr = AW'(32'(i_write_plane) * ROW_COUNT + 32'(i_write_row));
    assign rd_addr = AW'(32'(scan_plane) * ROW_COUNT + 32'(scan_row));

    lmbs_scan_ctrl #(
        .ROW_COUNT   (ROW_COUNT),
        .PLANE_COUNT (PLANE_COUNT)
    ) u_scan_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_tick         (tick_accept),
        .i_button_level (i_button_level),
        .o_row          (scan_row),
        .o_plane        (scan_plane),
        .o_result       (scan_result)
    );

    lmbs_frame_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (write_ok),
        .i_wcol   (i_write_column_byte),
        .i_waddr  (wr_addr),
        .i_wdata  (i_write_data),
        .i_re     (tick_accept),
        .i_raddr  (rd_addr),
        .o_first  (rd_first),
        .o_second (rd_second),
        .o_third  (rd_third)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (tick_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_accept) begin
            r_s1 <= scan_result;
        end
        if (s1_advance) begin
            r_out        <= r_s1;
            r_out_first  <= rd_first;
            r_out_second <= rd_second;
            r_out_third  <= rd_third;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_row_select     = r_out.row_select;
    assign o_columns_first  = r_out_first;
    assign o_columns_second = r_out_second;
    assign o_columns_third  = r_out_third;
    assign o_dwell_compare  = r_out.dwell;
    assign o_press_event    = r_out.press_event;
    assign o_press_pattern  = r_out.press_pattern;

    a_press_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_press_event == (o_press_pattern != '0)))
        else $error("press pattern does not agree with press event");

    a_row_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot(o_row_select))
        else $error("row select is not one-hot");

    a_tick_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_accept |=> r_s1_valid)
        else $error("accepted tick lost in the read stage");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_stall) |-> o_stall)
        else $error("input not stalled while both stages are full");

endmodule
`default_nettype wire
